>>> sv/gtcl_pkg.sv
// ----------------------------------------------------------------------------
// gtcl_pkg
// Shared types and constants for the gradient to correlation length block.
// ----------------------------------------------------------------------------
package gtcl_pkg;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 24;

  localparam logic [CFG_AW-1:0] CFG_MAX_LENGTH = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LENGTH_NUM = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MASK_DEPTH = 2'd2;

  localparam logic [15:0] MAX_LENGTH_RST = 16'd25000;
  localparam logic [15:0] LENGTH_NUM_RST = 16'd500;
  localparam logic signed [23:0] MASK_DEPTH_RST = 24'sd500;

  localparam int CORDIC_STEPS = 20;
  localparam int ATAN_W = 21;

  typedef struct packed {
    logic signed [23:0] grad_east;
    logic signed [23:0] grad_north;
    logic signed [23:0] depth_cm;
  } in_item_t;

  typedef struct packed {
    logic [23:0]        slope_mag;
    logic signed [15:0] dir_east;
    logic signed [15:0] dir_north;
    logic signed [15:0] azimuth_cdeg;
    logic [15:0]        length_along;
    logic [15:0]        length_east;
    logic [15:0]        length_north;
    logic               masked;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        max_length;
    logic [15:0]        length_numerator;
    logic signed [23:0] mask_depth;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] e;
    logic signed [23:0] n;
    logic [23:0]        ae;
    logic [23:0]        an;
    logic               masked;
  } q_item_t;

  // arctangent of 2^-i in 1/256 hundredths of a degree
  function automatic logic [ATAN_W-1:0] atan_val(input int i);
    logic [ATAN_W-1:0] v;
    case (i)
      0:  v = 21'd1152000;
      1:  v = 21'd680065;
      2:  v = 21'd359328;
      3:  v = 21'd182400;
      4:  v = 21'd91554;
      5:  v = 21'd45822;
      6:  v = 21'd22916;
      7:  v = 21'd11459;
      8:  v = 21'd5730;
      9:  v = 21'd2865;
      10: v = 21'd1432;
      11: v = 21'd716;
      12: v = 21'd358;
      13: v = 21'd179;
      14: v = 21'd90;
      15: v = 21'd45;
      16: v = 21'd22;
      17: v = 21'd11;
      18: v = 21'd6;
      19: v = 21'd3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/gtcl_if.sv
// ----------------------------------------------------------------------------
// gtcl_if
// Valid/ready stream channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface gtcl_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/gtcl_cfg.sv
// ----------------------------------------------------------------------------
// gtcl_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module gtcl_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gtcl_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [gtcl_pkg::CFG_DW-1:0]   cfg_wdata,
  output gtcl_pkg::cfg_t                cfg
);
  import gtcl_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_length       <= MAX_LENGTH_RST;
      cfg_r.length_numerator <= LENGTH_NUM_RST;
      cfg_r.mask_depth       <= MASK_DEPTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_LENGTH: cfg_r.max_length       <= cfg_wdata[15:0];
        CFG_LENGTH_NUM: cfg_r.length_numerator <= cfg_wdata[15:0];
        CFG_MASK_DEPTH: cfg_r.mask_depth       <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/gtcl_front.sv
// ----------------------------------------------------------------------------
// gtcl_front
// Input stage: takes a cell, flags masking and forms gradient magnitudes.
// ----------------------------------------------------------------------------
module gtcl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  gtcl_pkg::cfg_t    cfg,
  gtcl_if.sink              in_ch,
  input  logic              q_full,
  output logic              q_push,
  output gtcl_pkg::q_item_t q_data
);
  import gtcl_pkg::*;

  logic    fv_r, fv_nxt;
  q_item_t fd_r, fd_nxt;
  logic    acc;

  assign in_ch.ready = !fv_r || !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign q_push      = fv_r && !q_full;

  always_comb begin
    fv_nxt = fv_r;
    if (acc) begin
      fv_nxt = 1'b1;
    end else if (q_push) begin
      fv_nxt = 1'b0;
    end
    fd_nxt.e      = in_ch.data.grad_east;
    fd_nxt.n      = in_ch.data.grad_north;
    fd_nxt.ae     = in_ch.data.grad_east[23] ? 24'(-in_ch.data.grad_east)
                                             : 24'(in_ch.data.grad_east);
    fd_nxt.an     = in_ch.data.grad_north[23] ? 24'(-in_ch.data.grad_north)
                                              : 24'(in_ch.data.grad_north);
    fd_nxt.masked = in_ch.data.depth_cm > cfg.mask_depth;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fd_r <= fd_nxt;
    end
  end

  assign q_data = fd_r;

endmodule

>>> sv/gtcl_fifo.sv
// ----------------------------------------------------------------------------
// gtcl_fifo
// Short queue between the input stage and the compute pipeline.
// ----------------------------------------------------------------------------
module gtcl_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output T     pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  T                mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == CNTW'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

>>> sv/gtcl_back.sv
// ----------------------------------------------------------------------------
// gtcl_back
// Compute pipeline: squares, root, cordic azimuth, dividers, output register.
// ----------------------------------------------------------------------------
module gtcl_back #(
  parameter int GRAD_FRAC_BITS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gtcl_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  gtcl_pkg::q_item_t q_data,
  output logic              q_pop,
  gtcl_if.source            out_ch
);
  import gtcl_pkg::*;

  localparam int DW      = (16 + GRAD_FRAC_BITS > 40) ? 16 + GRAD_FRAC_BITS : 40;
  localparam int CW      = 34;
  localparam int ZW      = 25;
  localparam int NL      = 5;
  localparam int S_SUM   = 1;
  localparam int S_SQ0   = 2;
  localparam int SQ_N    = 24;
  localparam int S_DSET  = S_SQ0 + SQ_N;
  localparam int S_DIV0  = S_DSET + 1;
  localparam int S_ROUND = CORDIC_STEPS + 1;
  localparam int NS      = S_DIV0 + 16;

  localparam logic signed [ZW-1:0] Z90    = 2304000;
  localparam logic signed [ZW-1:0] Z_HALF = 128;
  localparam logic signed [ZW-1:0] AZ_MAX = 18000;
  localparam logic signed [ZW-1:0] AZ_MIN = -18000;

  typedef struct packed {
    logic                     masked;
    logic                     e_neg;
    logic                     n_neg;
    logic [23:0]              ae;
    logic [23:0]              an;
    logic [47:0]              v;
    logic [47:0]              r;
    logic signed [CW-1:0]     cx;
    logic signed [CW-1:0]     cy;
    logic signed [ZW-1:0]     cz;
    logic signed [15:0]       az;
    logic [NL-1:0][DW-1:0]    rem;
    logic [NL-1:0][15:0]      quo;
    logic [NL-1:0][23:0]      dvs;
    logic [2:0]               sat;
  } stg_t;

  stg_t          prv [NS];
  stg_t          pipe_nxt [NS];
  stg_t          pipe_r [NS];
  stg_t          stg_in;
  logic [NS-1:0] pv_r;
  logic          out_v_r;
  out_item_t     out_r, out_nxt;
  logic          adv;

  assign adv          = !out_v_r || out_ch.ready;
  assign q_pop        = adv && q_valid;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // stage 0 entry: squares and quarter turn into the right half plane
  always_comb begin
    logic signed [CW-1:0] x0, y0;
    stg_in        = '0;
    stg_in.masked = q_data.masked;
    stg_in.e_neg  = q_data.e[23];
    stg_in.n_neg  = q_data.n[23];
    stg_in.ae     = q_data.ae;
    stg_in.an     = q_data.an;
    stg_in.v      = 48'(q_data.ae) * 48'(q_data.ae);
    stg_in.r      = 48'(q_data.an) * 48'(q_data.an);
    x0 = CW'(q_data.e) <<< 6;
    y0 = CW'(q_data.n) <<< 6;
    stg_in.cx = x0;
    stg_in.cy = y0;
    stg_in.cz = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        stg_in.cx = y0;
        stg_in.cy = -x0;
        stg_in.cz = Z90;
      end else begin
        stg_in.cx = -y0;
        stg_in.cy = x0;
        stg_in.cz = -Z90;
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int SQ_SH = (k >= S_SQ0 && k < S_DSET) ? 46 - 2 * (k - S_SQ0) : 0;
    localparam int CI    = (k >= 1 && k <= CORDIC_STEPS) ? k - 1 : 0;
    localparam int DB    = (k >= S_DIV0) ? 15 - (k - S_DIV0) : 0;

    if (k == 0) begin : g_first
      assign prv[k] = stg_in;
    end else begin : g_next
      assign prv[k] = pipe_r[k-1];
    end

    always_comb begin
      logic [47:0]          trial;
      logic [DW-1:0]        sub;
      logic signed [CW-1:0] dx, dy;
      logic signed [ZW-1:0] at, zr;
      logic [23:0]          s;
      pipe_nxt[k] = prv[k];
      trial = '0;
      sub   = '0;
      dx    = '0;
      dy    = '0;
      at    = '0;
      zr    = '0;
      s     = '0;
      if (k == S_SUM) begin
        pipe_nxt[k].v = prv[k].v + prv[k].r;
        pipe_nxt[k].r = '0;
      end
      if (k >= S_SQ0 && k < S_DSET) begin
        trial = prv[k].r + (48'd1 << SQ_SH);
        if (prv[k].v >= trial) begin
          pipe_nxt[k].v = prv[k].v - trial;
          pipe_nxt[k].r = (prv[k].r >> 1) + (48'd1 << SQ_SH);
        end else begin
          pipe_nxt[k].r = prv[k].r >> 1;
        end
      end
      if (k >= 1 && k <= CORDIC_STEPS) begin
        dx = prv[k].cy >>> CI;
        dy = prv[k].cx >>> CI;
        at = signed'(ZW'(atan_val(CI)));
        if (prv[k].cy > 0) begin
          pipe_nxt[k].cx = prv[k].cx + dx;
          pipe_nxt[k].cy = prv[k].cy - dy;
          pipe_nxt[k].cz = prv[k].cz + at;
        end else begin
          pipe_nxt[k].cx = prv[k].cx - dx;
          pipe_nxt[k].cy = prv[k].cy + dy;
          pipe_nxt[k].cz = prv[k].cz - at;
        end
      end
      if (k == S_ROUND) begin
        if (prv[k].cz >= 0) begin
          zr = (prv[k].cz + Z_HALF) >>> 8;
        end else begin
          zr = -((-prv[k].cz + Z_HALF) >>> 8);
        end
        if (zr > AZ_MAX) begin
          zr = AZ_MAX;
        end else if (zr < AZ_MIN) begin
          zr = AZ_MIN;
        end
        pipe_nxt[k].az = 16'(zr);
      end
      if (k == S_DSET) begin
        s = prv[k].r[23:0];
        pipe_nxt[k].dvs[0] = s;
        pipe_nxt[k].dvs[1] = prv[k].ae;
        pipe_nxt[k].dvs[2] = prv[k].an;
        pipe_nxt[k].dvs[3] = s;
        pipe_nxt[k].dvs[4] = s;
        for (int l = 0; l < 3; l++) begin
          pipe_nxt[k].rem[l] = DW'(cfg.length_numerator) << GRAD_FRAC_BITS;
          pipe_nxt[k].sat[l] = (pipe_nxt[k].dvs[l] == '0) ||
                               (pipe_nxt[k].rem[l] >= (DW'(pipe_nxt[k].dvs[l]) << 16));
        end
        pipe_nxt[k].rem[3] = (DW'(prv[k].ae) << 15) + DW'(s >> 1);
        pipe_nxt[k].rem[4] = (DW'(prv[k].an) << 15) + DW'(s >> 1);
        pipe_nxt[k].quo    = '0;
      end
      if (k >= S_DIV0) begin
        for (int l = 0; l < NL; l++) begin
          sub = DW'(prv[k].dvs[l]) << DB;
          if (prv[k].rem[l] >= sub) begin
            pipe_nxt[k].rem[l]     = prv[k].rem[l] - sub;
            pipe_nxt[k].quo[l][DB] = 1'b1;
          end
        end
      end
    end
  end

  function automatic logic [15:0] clamp_len(input logic sat, input logic [15:0] q,
                                            input logic [15:0] lim);
    logic [15:0] v;
    if (sat || q > lim) begin
      v = lim;
    end else begin
      v = q;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] dir_of(input logic [15:0] q, input logic neg);
    logic signed [15:0] v;
    if (neg) begin
      v = (q > 16'd32768) ? 16'sh8000 : signed'(16'(16'd0 - q));
    end else begin
      v = (q > 16'd32767) ? 16'sh7fff : signed'(q);
    end
    return v;
  endfunction

  always_comb begin
    stg_t p;
    p       = pipe_r[NS-1];
    out_nxt = '0;
    if (p.masked) begin
      out_nxt.masked = 1'b1;
    end else begin
      out_nxt.slope_mag    = p.dvs[0];
      out_nxt.length_along = clamp_len(p.sat[0], p.quo[0], cfg.max_length);
      out_nxt.length_east  = clamp_len(p.sat[1], p.quo[1], cfg.max_length);
      out_nxt.length_north = clamp_len(p.sat[2], p.quo[2], cfg.max_length);
      if (p.dvs[0] != '0) begin
        out_nxt.dir_east     = dir_of(p.quo[3], p.e_neg);
        out_nxt.dir_north    = dir_of(p.quo[4], p.n_neg);
        out_nxt.azimuth_cdeg = p.az;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      pv_r    <= {pv_r[NS-2:0], q_valid};
      out_v_r <= pv_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        pipe_r[k] <= pipe_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

endmodule

>>> sv/gradient_to_correlation_length.sv
// ----------------------------------------------------------------------------
// gradient_to_correlation_length
// Per-cell slope, unit direction, azimuth and correlation lengths.
// ----------------------------------------------------------------------------
// path: an accepted cell passes the input register, the queue, the 43 compute stages and the output register
// throughput: one cell per cycle while the result word is taken, each of the 43 compute stages takes a cell a cycle
// root is 24 one-bit stages, azimuth 20 cordic stages, dividers 16 stages
// the whole pipeline holds while the result word waits to be taken
// reset: synchronous, clears all valids and loads register defaults
module gradient_to_correlation_length #(
  parameter int GRAD_FRAC_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [gtcl_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [gtcl_pkg::CFG_DW-1:0] cfg_wdata,
  gtcl_if.sink                        in_ch,
  gtcl_if.source                      out_ch
);
  import gtcl_pkg::*;

  cfg_t    cfg;
  logic    q_full, q_push, q_pop, q_valid;
  q_item_t q_wdata, q_rdata;

  gtcl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gtcl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  gtcl_fifo #(
    .DEPTH (2),
    .T     (q_item_t)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rdata)
  );

  gtcl_back #(
    .GRAD_FRAC_BITS (GRAD_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
